FILE: src/vqfl_pkg.sv
package vqfl_pkg;

  localparam int QUEUE_SIZE = 256;
  localparam int MAX_CHAIN  = 16;
  localparam int IDX_W      = 8;
  localparam int LEN_W      = 5;
  localparam int CNT_W      = $clog2(MAX_CHAIN + 1);
  localparam int FREE_W     = 9;
  localparam int BUF_W      = 32;
  // descriptor word: {length, write mark, chain mark, next link}
  localparam int DESC_W     = BUF_W + 2 + IDX_W;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_BROKEN  = 3'd1;
  localparam logic [2:0] STS_NOSPACE = 3'd2;
  localparam logic [2:0] STS_NOTHING = 3'd3;
  localparam logic [2:0] STS_BADCHN  = 3'd4;

  localparam logic CFG_BUF_SIZE = 1'b0;
  localparam logic CFG_BROKEN   = 1'b1;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       cur_link;
    logic       cur_head;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       set_nlen;
    logic       rd_en;
    logic       wr_alloc;
    logic       wr_recl;
    logic       commit_alloc;
    logic       commit_recl;
    logic       emit_err;
    logic [2:0] err_code;
    logic       emit_alloc;
    logic       emit_recl;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic broken;
    logic len_bad;
    logic no_space;
    logic nothing_used;
    logic chain;
    logic alloc_last;
    logic at_max;
    logic recl_last;
    logic out_free;
  } sts_t;

endpackage

FILE: src/vqfl_ram.sv
module vqfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/vqfl_ctrl.sv
module vqfl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  output logic            in_rdy,
  input  vqfl_pkg::sts_t  sts,
  output vqfl_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_A_RD   = 3'd2;
  localparam logic [2:0] S_A_USE  = 3'd3;
  localparam logic [2:0] S_R1_RD  = 3'd4;
  localparam logic [2:0] S_R1_USE = 3'd5;
  localparam logic [2:0] S_R2_RD  = 3'd6;
  localparam logic [2:0] S_R2_USE = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_rdy = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          priority if (sts.broken) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = vqfl_pkg::STS_BROKEN;
            state_nxt = S_IDLE;
          end else if (!sts.action && sts.len_bad) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = vqfl_pkg::STS_BADCHN;
            state_nxt = S_IDLE;
          end else if (!sts.action && sts.no_space) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = vqfl_pkg::STS_NOSPACE;
            state_nxt = S_IDLE;
          end else if (sts.action && sts.nothing_used) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = vqfl_pkg::STS_NOTHING;
            state_nxt = S_IDLE;
          end else begin
            cmd.start = 1'b1;
            cmd.cnt_clr = 1'b1;
            state_nxt = sts.action ? S_R1_RD : S_A_RD;
          end
        end
      end
      S_A_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_A_USE;
      end
      S_A_USE: begin
        if (sts.out_free) begin
          cmd.emit_alloc = 1'b1;
          cmd.wr_alloc = 1'b1;
          if (sts.alloc_last) begin
            cmd.commit_alloc = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.cur_link = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_nxt = S_A_RD;
          end
        end
      end
      S_R1_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_R1_USE;
      end
      S_R1_USE: begin
        // first pass only measures the chain, nothing is changed
        if (!sts.chain) begin
          cmd.set_nlen = 1'b1;
          cmd.cur_head = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt = S_R2_RD;
        end else if (sts.at_max) begin
          if (sts.out_free) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = vqfl_pkg::STS_BADCHN;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.cur_link = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt = S_R1_RD;
        end
      end
      S_R2_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_R2_USE;
      end
      S_R2_USE: begin
        if (sts.out_free) begin
          cmd.emit_recl = 1'b1;
          if (sts.recl_last) begin
            cmd.wr_recl = 1'b1;
            cmd.commit_recl = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.cur_link = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_nxt = S_R2_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: src/vqfl_dp.sv
module vqfl_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [vqfl_pkg::BUF_W-1:0]   cfg_wr_data,
  input  logic                         in_action,
  input  logic [31:0]                  in_data,
  input  vqfl_pkg::cmd_t               cmd,
  output vqfl_pkg::sts_t               sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [55:0]                  out_data,
  output logic                         out_last
);

  localparam int IW = vqfl_pkg::IDX_W;
  localparam int FW = vqfl_pkg::FREE_W;
  localparam int CW = vqfl_pkg::CNT_W;
  localparam int LW = vqfl_pkg::LEN_W;
  localparam int DW = vqfl_pkg::DESC_W;

  logic [vqfl_pkg::BUF_W-1:0] buf_size_r;
  logic                       broken_r;
  logic [IW-1:0]              free_head_r;
  logic [FW-1:0]              free_r;
  logic [15:0]                avail_r, used_r, added_r;
  logic                       act_r, dir_r;
  logic [LW-1:0]              len_r;
  logic [IW-1:0]              uhead_r, hd_r, cur_r;
  logic [15:0]                pidx_r;
  logic [CW-1:0]              cnt_r, nlen_r;
  logic [vqfl_pkg::QUEUE_SIZE-1:0] vld_r;
  logic                       rd_vld_r;
  logic [IW-1:0]              rd_addr_r;
  logic [DW-1:0]              ram_q, rword, wword;
  logic                       we;
  logic [IW-1:0]              link;
  logic                       out_valid_r;
  logic [2:0]                 out_status_r;
  logic [55:0]                out_data_r;
  logic                       out_last_r;
  logic [FW:0]                recl_sum;
  logic [FW-1:0]              recl_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= '0;
      broken_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vqfl_pkg::CFG_BUF_SIZE: buf_size_r <= cfg_wr_data;
        vqfl_pkg::CFG_BROKEN:   broken_r   <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // descriptor table; entries never written read as their reset link
  assign we = cmd.wr_alloc | cmd.wr_recl;
  vqfl_ram #(.WIDTH(DW), .DEPTH(vqfl_pkg::QUEUE_SIZE)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cur_r),
    .wdata (wword),
    .re    (cmd.rd_en),
    .raddr (cur_r),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[cur_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld_r  <= vld_r[cur_r];
      rd_addr_r <= cur_r;
    end
  end

  assign rword = rd_vld_r ? ram_q : {{(DW-IW){1'b0}}, rd_addr_r + IW'(1)};
  assign link  = rword[IW-1:0];

  always_comb begin
    if (cmd.wr_alloc) begin
      wword = {buf_size_r, ~dir_r, ~sts.alloc_last, link};
    end else begin
      wword = {rword[DW-1:IW], free_head_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      dir_r   <= in_data[0];
      len_r   <= in_data[5:1];
      uhead_r <= in_data[13:6];
      pidx_r  <= in_data[29:14];
    end
    if (cmd.start) begin
      hd_r  <= act_r ? uhead_r : free_head_r;
      cur_r <= act_r ? uhead_r : free_head_r;
    end else if (cmd.cur_head) begin
      cur_r <= hd_r;
    end else if (cmd.cur_link) begin
      cur_r <= link;
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.set_nlen) begin
      nlen_r <= cnt_r + CW'(1);
    end
  end

  assign recl_sum  = {1'b0, free_r} + (FW+1)'(nlen_r);
  assign recl_free = (recl_sum > (FW+1)'(vqfl_pkg::QUEUE_SIZE))
                     ? FW'(vqfl_pkg::QUEUE_SIZE) : recl_sum[FW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      free_r      <= FW'(vqfl_pkg::QUEUE_SIZE);
      avail_r     <= '0;
      used_r      <= '0;
      added_r     <= '0;
    end else if (cmd.commit_alloc) begin
      free_head_r <= link;
      free_r      <= free_r - FW'(len_r);
      avail_r     <= avail_r + 16'd1;
      added_r     <= added_r + 16'd1;
    end else if (cmd.commit_recl) begin
      free_head_r <= hd_r;
      free_r      <= recl_free;
      used_r      <= used_r + 16'd1;
    end
  end

  assign sts.action       = act_r;
  assign sts.broken       = broken_r;
  assign sts.len_bad      = (len_r == '0) || (len_r > LW'(vqfl_pkg::MAX_CHAIN));
  assign sts.no_space     = free_r < FW'(len_r);
  assign sts.nothing_used = used_r == pidx_r;
  assign sts.chain        = rword[IW];
  assign sts.alloc_last   = (LW'(cnt_r) + LW'(1)) == len_r;
  assign sts.at_max       = (CW'(cnt_r) + CW'(1)) >= CW'(vqfl_pkg::MAX_CHAIN);
  assign sts.recl_last    = (cnt_r + CW'(1)) == nlen_r;
  assign sts.out_free     = !out_valid_r || out_ready;

  // result beat: granted, free, kick, avail index, slot, writable, desc, head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_err || cmd.emit_alloc || cmd.emit_recl) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_status_r <= cmd.err_code;
      out_data_r   <= {5'd0, free_r,
                       (cmd.err_code == vqfl_pkg::STS_NOSPACE) & dir_r,
                       avail_r, 8'd0, 1'b0, 8'd0, 8'd0};
      out_last_r   <= 1'b1;
    end else if (cmd.emit_alloc) begin
      out_status_r <= vqfl_pkg::STS_OK;
      out_data_r   <= {len_r, free_r - FW'(len_r), 1'b0, avail_r + 16'd1,
                       avail_r[IW-1:0], ~dir_r, cur_r, hd_r};
      out_last_r   <= sts.alloc_last;
    end else if (cmd.emit_recl) begin
      out_status_r <= vqfl_pkg::STS_OK;
      out_data_r   <= {5'd0, recl_free, 1'b0, avail_r, 8'd0,
                       rword[IW+1], cur_r, hd_r};
      out_last_r   <= sts.recl_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

FILE: src/virtq_descriptor_free_list_core.sv
// Driver-side split-ring descriptor manager. A beat with in_tuser 0 allocates a chain
// of chain_length descriptors from the free list; in_tuser 1 reclaims the used chain
// at used_head when partner_used_index differs from the local used count. Each
// descriptor handed out or returned gives one result beat, errors give a single beat
// whose status is on out_tuser; out_tlast closes every item. Items are handled one at
// a time: the descriptor table is read and written at the current descriptor with a
// registered read, so each link takes a read state and then a use state. An allocation
// walks the chain once; a reclaim makes one pass to measure the chain and one to return
// it, and a reclaim chain that runs past the chain limit ends in an error beat. A result
// beat that out_tready holds back stalls the item.
// buffer_size is stored as the length of every allocated descriptor.
module virtq_descriptor_free_list_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // direction, chain_length, used_head, partner_used_index
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // head_index, desc_index, writable, avail_slot,
                                  // avail_index, kick_request, free_count, granted_count
  output logic [2:0]  out_tuser,  // status
  output logic        out_tlast
);

  vqfl_pkg::cmd_t cmd;
  vqfl_pkg::sts_t sts;

  vqfl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid & in_tready),
    .in_rdy  (in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  vqfl_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_action   (in_tuser),
    .in_data     (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_data    (out_tdata),
    .out_last    (out_tlast)
  );

endmodule

FILE: src/vqfl_checker.sv
module vqfl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // error beats close their item and grant nothing
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != vqfl_pkg::STS_OK |-> out_tlast && out_tdata[55:51] == 5'd0)
    else $error("error beat not final or has grant");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[50:42] <= 9'd256)
    else $error("free count above queue size");

  // no result beat ever shows a grant above the chain limit
  a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:51] <= 5'd16)
    else $error("grant above chain limit");

endmodule

bind virtq_descriptor_free_list_core vqfl_checker u_vqfl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: tb/sv/virtq_descriptor_free_list_core_test.sv
module virtq_descriptor_free_list_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  head;
    logic [7:0]  desc;
    logic        writable;
    logic [7:0]  slot;
    logic [15:0] avail_num;
    logic        kick;
    logic [8:0]  free_cnt;
    logic [4:0]  granted;
    logic        last;
  } result_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = vqfl_pkg::CFG_BUF_SIZE;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  virtq_descriptor_free_list_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // free list model
  logic [7:0]  link_tbl[vqfl_pkg::QUEUE_SIZE];
  logic        chained[vqfl_pkg::QUEUE_SIZE];
  logic        dev_writable[vqfl_pkg::QUEUE_SIZE];
  logic [7:0]  list_head;
  int          free_descs;
  logic [15:0] avail_cnt;
  logic [15:0] used_cnt;
  logic [31:0] buf_size;
  logic        broken;

  result_beat_t expected_beats[$];
  logic [7:0]   posted_heads[$];
  int           errors = 0;
  int           cycles = 0;
  bit           in_quiet = 0;
  bit           out_quiet = 0;
  logic         hold_req = 1'b0;
  int           hold_left = 0;

  function automatic void push_beat(logic [2:0] st, logic [7:0] head, logic [7:0] desc,
                                    logic wr, logic [7:0] slot, logic kick,
                                    logic [4:0] granted, logic last);
    result_beat_t b;
    b.status = st; b.head = head; b.desc = desc; b.writable = wr; b.slot = slot;
    b.avail_num = avail_cnt; b.kick = kick; b.free_cnt = free_descs[8:0];
    b.granted = granted; b.last = last;
    expected_beats.push_back(b);
  endfunction

  function automatic void predict_chain_op(logic act, logic dir, logic [4:0] len,
                                           logic [7:0] uhead, logic [15:0] pidx);
    logic [7:0] idx;
    logic [7:0] prev;
    logic [7:0] head;
    logic [7:0] slot;
    logic [7:0] walk[$];
    logic       wr;
    if (broken) begin
      push_beat(vqfl_pkg::STS_BROKEN, 0, 0, 0, 0, 0, 0, 1);
    end else if (act == 1'b0) begin
      wr = !dir;
      if (len == 0 || len > vqfl_pkg::MAX_CHAIN) begin
        push_beat(vqfl_pkg::STS_BADCHN, 0, 0, 0, 0, 0, 0, 1);
      end else if (free_descs < len) begin
        push_beat(vqfl_pkg::STS_NOSPACE, 0, 0, 0, 0, dir, 0, 1);
      end else begin
        head = list_head;
        idx = head;
        prev = head;
        for (int n = 0; n < len; n++) begin
          chained[idx] = 1'b1;
          dev_writable[idx] = wr;
          prev = idx;
          idx = link_tbl[idx];
        end
        chained[prev] = 1'b0;
        free_descs -= len;
        list_head = idx;
        slot = avail_cnt[7:0];
        avail_cnt++;
        posted_heads.push_back(head);
        idx = head;
        for (int n = 0; n < len; n++) begin
          push_beat(vqfl_pkg::STS_OK, head, idx, wr, slot, 0, len, n + 1 == len);
          idx = link_tbl[idx];
        end
      end
    end else if (used_cnt == pidx) begin
      push_beat(vqfl_pkg::STS_NOTHING, 0, 0, 0, 0, 0, 0, 1);
    end else begin
      idx = uhead;
      walk.push_back(idx);
      while (chained[idx] && walk.size() < vqfl_pkg::MAX_CHAIN + 1) begin
        if (walk.size() >= vqfl_pkg::MAX_CHAIN) break;
        idx = link_tbl[idx];
        walk.push_back(idx);
      end
      if (chained[idx]) begin
        // chain still marked after the link cap
        push_beat(vqfl_pkg::STS_BADCHN, 0, 0, 0, 0, 0, 0, 1);
      end else begin
        link_tbl[idx] = list_head;
        list_head = uhead;
        free_descs += walk.size();
        if (free_descs > vqfl_pkg::QUEUE_SIZE) free_descs = vqfl_pkg::QUEUE_SIZE;
        used_cnt++;
        foreach (walk[k])
          push_beat(vqfl_pkg::STS_OK, uhead, walk[k], dev_writable[walk[k]], 0, 0, 0,
                    k + 1 == walk.size());
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[31:0], 0);
      end else begin
        e = expected_beats.pop_front();
        if (out_tuser != e.status) report_mismatch("status", out_tuser, e.status);
        if (out_tdata[7:0] != e.head) report_mismatch("head_index", out_tdata[7:0], e.head);
        if (out_tdata[15:8] != e.desc) report_mismatch("desc_index", out_tdata[15:8], e.desc);
        if (out_tdata[16] != e.writable) report_mismatch("writable", out_tdata[16], e.writable);
        if (out_tdata[24:17] != e.slot) report_mismatch("avail_slot", out_tdata[24:17], e.slot);
        if (out_tdata[40:25] != e.avail_num)
          report_mismatch("avail_index", out_tdata[40:25], e.avail_num);
        if (out_tdata[41] != e.kick) report_mismatch("kick_request", out_tdata[41], e.kick);
        if (out_tdata[50:42] != e.free_cnt)
          report_mismatch("free_count", out_tdata[50:42], e.free_cnt);
        if (out_tdata[55:51] != e.granted)
          report_mismatch("granted_count", out_tdata[55:51], e.granted);
        if (out_tlast != e.last) report_mismatch("last", out_tlast, e.last);
      end
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= out_quiet || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(logic act, logic dir, logic [4:0] len, logic [7:0] uhead,
                           logic [15:0] pidx);
    if (!in_quiet && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {2'b00, pidx, uhead, len, dir};
    do @(posedge clk); while (!in_tready);
    predict_chain_op(act, dir, len, uhead, pidx);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == vqfl_pkg::CFG_BUF_SIZE) buf_size = val;
    else broken = val[0];
    @(posedge clk);
  endtask

  task automatic reclaim_next();
    send_item(1'b1, 1'($urandom_range(1)), 5'($urandom_range(31)),
              posted_heads.pop_front(), used_cnt + 16'd1);
  endtask

  task automatic test_basic_ops();
    write_reg(vqfl_pkg::CFG_BUF_SIZE, 32'hffff_ffff);
    write_reg(vqfl_pkg::CFG_BROKEN, 32'd0);
    send_item(1'b1, 1'b0, 5'd1, 8'd0, 16'd0);        // nothing used
    send_item(1'b1, 1'b1, 5'd31, 8'd255, 16'hffff);  // free count saturates
    send_item(1'b0, 1'b0, 5'd1, 8'd0, 16'd0);
    send_item(1'b0, 1'b1, 5'd16, 8'hff, 16'hffff);
    send_item(1'b0, 1'b0, 5'd0, 8'd0, 16'd0);        // bad length
    send_item(1'b0, 1'b1, 5'd17, 8'd0, 16'd0);
    send_item(1'b0, 1'b0, 5'd31, 8'd0, 16'd0);
    reclaim_next();
    reclaim_next();
    send_item(1'b1, 1'b0, 5'd3, 8'd7, used_cnt);     // nothing used, nonzero index
    drain();
  endtask

  task automatic test_no_space_backpressure();
    write_reg(vqfl_pkg::CFG_BUF_SIZE, 32'd0);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    // sender keeps offering while results are held back
    for (int n = 0; n < 16; n++) send_item(1'b0, n[0], 5'd16, 8'd0, 16'd0);
    send_item(1'b0, 1'b0, 5'd1, 8'd0, 16'd0);
    send_item(1'b0, 1'b1, 5'd16, 8'd0, 16'd0);
    drain();
    while (posted_heads.size() > 0) reclaim_next();
    drain();
  endtask

  task automatic test_broken_queue();
    write_reg(vqfl_pkg::CFG_BROKEN, 32'd1);
    send_item(1'b0, 1'b0, 5'd4, 8'd0, 16'd0);
    send_item(1'b1, 1'b1, 5'd0, 8'd3, used_cnt + 16'd1);
    drain();
    write_reg(vqfl_pkg::CFG_BROKEN, 32'd0);
  endtask

  task automatic test_random_traffic(int items);
    int pick;
    for (int n = 0; n < items; n++) begin
      in_quiet = (n >= 150 && n < 220);
      out_quiet = in_quiet;
      if (n == 300) begin
        drain();
        write_reg(vqfl_pkg::CFG_BUF_SIZE, $urandom());
      end
      pick = $urandom_range(99);
      if (pick < 45)
        send_item(1'b0, 1'($urandom_range(1)),
                  $urandom_range(99) < 80 ? 5'($urandom_range(4, 1))
                                          : 5'($urandom_range(16, 1)),
                  8'($urandom_range(255)), 16'($urandom_range(65535)));
      else if (pick < 85 && posted_heads.size() > 0)
        reclaim_next();
      else if (pick < 90)
        send_item(1'b1, 1'($urandom_range(1)), 5'($urandom_range(31)),
                  8'($urandom_range(255)), used_cnt);
      else if (pick < 95)
        send_item(1'b1, 1'($urandom_range(1)), 5'($urandom_range(31)),
                  8'($urandom_range(255)), 16'($urandom_range(65535)));
      else
        send_item(1'b0, 1'($urandom_range(1)), 5'($urandom_range(31)),
                  8'($urandom_range(255)), 16'($urandom_range(65535)));
    end
    in_quiet = 0;
    out_quiet = 0;
    drain();
  endtask

  initial begin
    foreach (link_tbl[i]) begin
      link_tbl[i] = 8'(i + 1);
      chained[i] = 1'b0;
      dev_writable[i] = 1'b0;
    end
    list_head = 0;
    free_descs = vqfl_pkg::QUEUE_SIZE;
    avail_cnt = 0;
    used_cnt = 0;
    buf_size = 0;
    broken = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_no_space_backpressure();
    test_broken_queue();
    test_random_traffic(335);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
